>>> rtl/grd_pkg.sv
// Shared constants and types for the grid ray traversal block.
`default_nettype none
package grd_pkg;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;

  localparam int DEPTH     = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int MAX_DIM   = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int LIM_W     = ($clog2(MAX_DIM + 1) > 7) ? $clog2(MAX_DIM + 1) : 7;
  localparam int COORD_W   = LIM_W + 1;

  localparam int DIST_W    = 24;
  localparam int MAG_W     = 16;
  localparam int QUO_W     = DIST_W + 1;
  localparam int QCNT_W    = $clog2(QUO_W);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    REASON_WALL  = 2'd0,
    REASON_EXIT  = 2'd1,
    REASON_RANGE = 2'd2
  } reason_t;

  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;
endpackage
`default_nettype wire

>>> rtl/grid_ray_traversal_dda_top.sv
// Top level of the grid ray caster: tile map, DDA walk and result register.
// A map write goes straight into the map. A cast waits on the two reciprocal dividers run
// side by side, then forms the first side products, then walks cell by cell (step, then the
// map read and test; a stop at the map edge or range skips the read) and loads the result.
// One item is worked at a time; the input is free again once the result register is loaded.
// After reset the map is swept to zero with no item taken; configuration is still accepted.
`default_nettype none
module grid_ray_traversal_dda_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_action,
  input  wire logic [5:0]          in_cell_col,
  input  wire logic [5:0]          in_cell_row,
  input  wire logic [7:0]          in_cell_value,
  input  wire logic [15:0]         in_pos_x,
  input  wire logic [15:0]         in_pos_y,
  input  wire logic signed [15:0]  in_dir_x,
  input  wire logic signed [15:0]  in_dir_y,
  input  wire logic [23:0]         in_max_range,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_stop_reason,
  output logic                     out_hit_side,
  output logic [23:0]              out_distance,
  output logic signed [7:0]        out_end_col,
  output logic signed [7:0]        out_end_row,
  output logic [7:0]               out_wall_value,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [6:0]          cfg_data
);
  import grd_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RECIP, S_FIRST, S_STEP, S_CHECK, S_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [ADDR_W-1:0]         clr_r, clr_nxt;
  logic [6:0]                cols_r, cols_nxt, rows_r, rows_nxt;
  logic                      negx_r, negx_nxt, negy_r, negy_nxt;
  logic [9:0]                fx_r, fx_nxt, fy_r, fy_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [DIST_W-1:0]         rng_r, rng_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;
  logic                      side_r, side_nxt;
  reason_t                   reason_r, reason_nxt;
  logic [7:0]                wall_r, wall_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      in_acc, cast_acc, wr_acc;
  logic [MAG_W-1:0]          magx, magy;
  logic                      dx_done, dy_done;
  logic [DIST_W-1:0]         ddx, ddy;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [7:0]                ram_wdata, ram_rdata;

  // Map size in use, capped at the store size.
  logic [LIM_W-1:0]          cols_lim, rows_lim;

  // Walk step terms.
  logic                      take_x;
  logic signed [COORD_W-1:0] cx_step, cy_step;
  logic [DIST_W-1:0]         dist_step;
  logic [DIST_W:0]           sx_sum, sy_sum;
  logic                      leave, over;

  // First side terms.
  logic [10:0]               frx, fry;
  logic [DIST_W+10:0]        prx, pry;

  assign in_acc   = in_valid && !in_stall;
  assign cast_acc = in_acc && (in_action == ACT_CAST);
  assign wr_acc   = in_acc && (in_action == ACT_WRITE);
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign magx = in_dir_x[15] ? MAG_W'(-in_dir_x) : MAG_W'(in_dir_x);
  assign magy = in_dir_y[15] ? MAG_W'(-in_dir_y) : MAG_W'(in_dir_y);

  grd_recip u_recip_x (
    .clk(clk), .rst_n(rst_n), .start(cast_acc), .mag(magx), .done(dx_done), .recip(ddx)
  );
  grd_recip u_recip_y (
    .clk(clk), .rst_n(rst_n), .start(cast_acc), .mag(magy), .done(dy_done), .recip(ddy)
  );

  grd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    cols_lim = (LIM_W'(cols_r) > LIM_W'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS) : LIM_W'(cols_r);
    rows_lim = (LIM_W'(rows_r) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : LIM_W'(rows_r);

    // Cross the nearer side; a tie crosses the y side.
    take_x    = (sx_r < sy_r);
    cx_step   = take_x ? (negx_r ? cx_r - COORD_W'(1) : cx_r + COORD_W'(1)) : cx_r;
    cy_step   = take_x ? cy_r : (negy_r ? cy_r - COORD_W'(1) : cy_r + COORD_W'(1));
    dist_step = take_x ? sx_r : sy_r;
    sx_sum    = {1'b0, sx_r} + {1'b0, ddx};
    sy_sum    = {1'b0, sy_r} + {1'b0, ddy};
    leave     = cx_step[COORD_W-1] || cy_step[COORD_W-1] ||
                (cx_step >= $signed({1'b0, cols_lim})) ||
                (cy_step >= $signed({1'b0, rows_lim}));
    over      = (rng_r != '0) && (dist_step > rng_r);

    frx = negx_r ? {1'b0, fx_r} : (11'd1024 - {1'b0, fx_r});
    fry = negy_r ? {1'b0, fy_r} : (11'd1024 - {1'b0, fy_r});
    prx = (DIST_W+11)'(frx) * (DIST_W+11)'(ddx);
    pry = (DIST_W+11)'(fry) * (DIST_W+11)'(ddy);

    ram_we    = 1'b0;
    ram_wdata = in_cell_value;
    ram_addr  = ADDR_W'(ADDR_W'(cy_step[COORD_W-2:0]) * ADDR_W'(MAX_COLUMNS)
                + ADDR_W'(cx_step[COORD_W-2:0]));

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rng_nxt       = rng_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    dist_nxt      = dist_r;
    side_nxt      = side_r;
    reason_nxt    = reason_r;
    wall_nxt      = wall_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COLUMNS) begin
        cols_nxt = cfg_data;
      end else if (cfg_index == REG_ROWS) begin
        rows_nxt = cfg_data;
      end
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (wr_acc) begin
          ram_addr = ADDR_W'(ADDR_W'(in_cell_row) * ADDR_W'(MAX_COLUMNS)
                     + ADDR_W'(in_cell_col));
          ram_we   = ({26'd0, in_cell_col} < MAX_COLUMNS) &&
                     ({26'd0, in_cell_row} < MAX_ROWS);
        end else if (cast_acc) begin
          negx_nxt  = in_dir_x[15];
          negy_nxt  = in_dir_y[15];
          fx_nxt    = in_pos_x[9:0];
          fy_nxt    = in_pos_y[9:0];
          cx_nxt    = $signed(COORD_W'(in_pos_x[15:10]));
          cy_nxt    = $signed(COORD_W'(in_pos_y[15:10]));
          rng_nxt   = in_max_range;
          state_nxt = S_RECIP;
        end
      end
      S_RECIP: begin
        if (dx_done && dy_done) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        sx_nxt    = prx[DIST_W+10] ? DIST_MAX : prx[DIST_W+9:10];
        sy_nxt    = pry[DIST_W+10] ? DIST_MAX : pry[DIST_W+9:10];
        dist_nxt  = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cx_nxt   = cx_step;
        cy_nxt   = cy_step;
        dist_nxt = dist_step;
        side_nxt = !take_x;
        if (take_x) begin
          sx_nxt = sx_sum[DIST_W] ? DIST_MAX : sx_sum[DIST_W-1:0];
        end else begin
          sy_nxt = sy_sum[DIST_W] ? DIST_MAX : sy_sum[DIST_W-1:0];
        end
        wall_nxt = '0;
        if (leave) begin
          reason_nxt = REASON_EXIT;
          state_nxt  = S_DONE;
        end else if (over) begin
          reason_nxt = REASON_RANGE;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ram_rdata != '0) begin
          reason_nxt = REASON_WALL;
          wall_nxt   = ram_rdata;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cols_r      <= 7'd64;
      rows_r      <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
    negx_r   <= negx_nxt;
    negy_r   <= negy_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    rng_r    <= rng_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    dist_r   <= dist_nxt;
    side_r   <= side_nxt;
    reason_r <= reason_nxt;
    wall_r   <= wall_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_stop_reason <= reason_r;
      out_hit_side    <= side_r;
      out_distance    <= dist_r;
      out_end_col     <= cx_r[7:0];
      out_end_row     <= cy_r[7:0];
      out_wall_value  <= wall_r;
    end
  end

  assign out_valid = out_valid_r;

  // The result register is never loaded while the map is being swept.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r) else $error("result during map sweep");

  // Only wall hits carry a cell value.
  a_wall_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_reason != REASON_WALL) |-> out_wall_value == '0)
    else $error("wall value on non-wall stop");

  // A step either ends the walk or reads the next cell.
  a_step_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |=> (state_r == S_CHECK || state_r == S_DONE))
    else $error("bad state after step");

  // The walk only starts once both reciprocals are finished.
  a_recip_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIRST |-> (dx_done && dy_done)) else $error("reciprocal not ready");
endmodule
`default_nettype wire

>>> rtl/grd_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module grd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/grd_recip.sv
// Bit-serial restoring divider giving the saturated reciprocal 2^24 / magnitude.
`default_nettype none
module grd_recip (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [grd_pkg::MAG_W-1:0] mag,
  output logic                           done,
  output logic [grd_pkg::DIST_W-1:0]     recip
);
  import grd_pkg::*;

  logic [MAG_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [MAG_W:0]    trial;
  logic              qbit;

  always_comb begin
    trial    = {rem_r, (cnt_r == QCNT_W'(QUO_W - 1))};
    qbit     = (trial >= {1'b0, mag_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mag_nxt  = mag_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = '0;
      mag_nxt  = mag;
      cnt_nxt  = QCNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? MAG_W'(trial - {1'b0, mag_r}) : MAG_W'(trial);
      quo_nxt = {quo_r[QUO_W-2:0], qbit};
      cnt_nxt = cnt_r - QCNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    mag_r <= mag_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done  = !busy_r;
  assign recip = (mag_r == '0 || quo_r[QUO_W-1]) ? DIST_MAX : quo_r[DIST_W-1:0];
endmodule
`default_nettype wire
